### src/ura_pkg.sv
// ============================================================================
// ura_pkg
// Shared widths, constants, codes and types of the ultrasonic range averager.
// ============================================================================
package ura_pkg;

    localparam int CM_W       = 11;
    localparam int BATCH_W    = 8;
    localparam int TMO_W      = 20;
    localparam int SUM_W      = 19;
    localparam int DEN_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int DIST_W     = 21;
    localparam int QT_W       = 17;
    localparam int Y_W        = 18;
    localparam int RCP_SHIFT  = 24;

    localparam logic [CM_W-1:0]    CM_MAX      = 11'd1795;
    localparam logic [BATCH_W-1:0] SAMPLES_MAX = 8'd255;

    localparam logic [DIST_W-1:0]  DIST_SAT    = 21'd1048870;
    localparam logic [DIST_W-1:0]  RCP_TEN     = 21'd1677722;
    localparam logic [Y_W-1:0]     RCP_73      = 18'd229825;

    localparam logic [BATCH_W-1:0] BATCH_RESET = 8'd25;
    localparam logic [CM_W-1:0]    STOP_RESET  = 11'd5;
    localparam logic [TMO_W-1:0]   TMO_RESET   = 20'd1000000;

    localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT_HIGH,
        PH_MEASURE
    } phase_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_STEP,
        CS_CM_A,
        CS_CM_B,
        CS_SUM,
        CS_AVG,
        CS_OUT
    } ctl_state_t;

    typedef struct packed {
        logic take_in;
        logic step;
        logic cm_stage;
        logic div_start;
        logic add_sample;
        logic finish_avg;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic complete;
        logic div_done;
        logic batch_full;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic            trigger_out;
        logic            drive_forward;
        logic            sample_valid;
        logic [CM_W-1:0] sample_cm;
        logic            sample_timed_out;
        logic            average_valid;
        logic [CM_W-1:0] average_cm;
        logic            run_done;
    } result_t;

endpackage

### src/ura_tick_if.sv
// ============================================================================
// ura_tick_if
// Input channel: one word per 10 us tick with echo level and start request.
// ============================================================================
interface ura_tick_if;

    logic valid;
    logic ready;
    logic echo_level;
    logic start_run;

    modport source (output valid, output echo_level, output start_run, input ready);
    modport sink   (input valid, input echo_level, input start_run, output ready);

endinterface

### src/ura_result_if.sv
// ============================================================================
// ura_result_if
// Output channel: one word per tick with pin drives, sample and average.
// ============================================================================
interface ura_result_if import ura_pkg::*; ();

    logic            valid;
    logic            ready;
    logic            trigger_out;
    logic            drive_forward;
    logic            sample_valid;
    logic [CM_W-1:0] sample_cm;
    logic            sample_timed_out;
    logic            average_valid;
    logic [CM_W-1:0] average_cm;
    logic            run_done;

    modport source (
        output valid, output trigger_out, output drive_forward, output sample_valid,
        output sample_cm, output sample_timed_out, output average_valid,
        output average_cm, output run_done, input ready
    );
    modport sink (
        input valid, input trigger_out, input drive_forward, input sample_valid,
        input sample_cm, input sample_timed_out, input average_valid,
        input average_cm, input run_done, output ready
    );

endinterface

### src/ura_divider.sv
// ============================================================================
// ura_divider
// Restoring divider, one quotient bit per cycle; done pulses when finished.
// ============================================================================
module ura_divider #(
    parameter int DIV_W = 20,
    parameter int DN_W  = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [DN_W-1:0]  den,
    output logic [DIV_W-1:0] quot,
    output logic             done
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [DN_W-1:0]  rem_reg, rem_next;
    logic [DN_W-1:0]  den_reg, den_next;
    logic [DN_W:0]    trial;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, num_reg[DIV_W-1]};
        fits      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W - 1);
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_W-2:0], fits};
            rem_next = fits ? DN_W'(trial - {1'b0, den_reg}) : trial[DN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quot = num_reg;
    assign done = done_reg;

endmodule

### src/ura_datapath.sv
// ============================================================================
// ura_datapath
// Ranging phase, counters, batch sum, configuration and output register.
// ============================================================================
module ura_datapath import ura_pkg::*; #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  echo_level,
    input  logic                  start_run,
    input  ctl_cmd_t              cmd,
    output dp_status_t            status,
    ura_result_if.source          result
);

    localparam int CMP_W = (COUNT_WIDTH > TMO_W) ? COUNT_WIDTH : TMO_W;
    localparam int EXT_W = (COUNT_WIDTH > DIST_W) ? COUNT_WIDTH : DIST_W;
    localparam int PT_W  = 2 * DIST_W;
    localparam int FQ_W  = QT_W + 3;
    localparam int PC_W  = 2 * Y_W;
    localparam int CMF_W = CM_W + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [BATCH_W-1:0]     batch_reg;
    logic [CM_W-1:0]        stop_reg;
    logic [TMO_W-1:0]       timeout_reg;
    logic                   echo_reg;
    logic                   start_reg;
    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [BATCH_W-1:0]     samples_reg, samples_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    result_t                work_reg, work_next;
    result_t                out_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0] width_reg;
    logic [QT_W-1:0]        q_reg;

    phase_t                 step_phase;
    logic [COUNT_WIDTH-1:0] step_tick;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [COUNT_WIDTH-1:0] width;
    logic                   limit_hit;
    logic                   clear_batch;
    logic                   complete;
    logic                   timed_out;
    logic                   drive;
    logic                   trig;

    logic [DIST_W-1:0]      dist_w;
    logic [PT_W-1:0]        prod_ten;
    logic [QT_W-1:0]        q_calc;
    logic [FQ_W-1:0]        five_q;
    logic [PC_W-1:0]        prod_cm;
    logic [CMF_W-1:0]       cm_full;

    logic [SUM_W-1:0]       div_num;
    logic [DEN_W-1:0]       div_den;
    logic [SUM_W-1:0]       quot;
    logic                   div_done;
    logic [CM_W-1:0]        sample_cm;
    logic [CM_W-1:0]        avg_cm;
    logic [BATCH_W-1:0]     eff_batch;

    // ranging step for the latched tick
    always_comb
    begin
        tick_inc    = (tick_reg == COUNT_MAX) ? tick_reg : COUNT_WIDTH'(tick_reg + 1'b1);
        limit_hit   = (CMP_W'(tick_inc) >= CMP_W'(timeout_reg)) || (tick_inc == COUNT_MAX);
        step_phase  = phase_reg;
        step_tick   = tick_reg;
        clear_batch = 1'b0;
        complete    = 1'b0;
        timed_out   = 1'b0;
        width       = '0;
        drive       = 1'b1;
        trig        = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                drive = start_reg;
                if (start_reg)
                begin
                    clear_batch = 1'b1;
                    step_tick   = '0;
                    step_phase  = PH_TRIG;
                end
            end
            PH_TRIG:
            begin
                trig       = 1'b1;
                step_tick  = '0;
                step_phase = PH_WAIT_HIGH;
            end
            PH_WAIT_HIGH:
            begin
                if (echo_reg)
                begin
                    step_tick  = COUNT_WIDTH'(1);
                    step_phase = PH_MEASURE;
                end
                else
                begin
                    step_tick = tick_inc;
                    complete  = limit_hit;
                    timed_out = limit_hit;
                end
            end
            PH_MEASURE:
            begin
                if (!echo_reg)
                begin
                    complete = 1'b1;
                    width    = tick_reg;
                end
                else
                begin
                    step_tick = tick_inc;
                    complete  = limit_hit;
                    timed_out = limit_hit;
                    width     = tick_inc;
                end
            end
            default:
            begin
                step_phase = PH_IDLE;
            end
        endcase
        if (complete)
        begin
            step_tick  = '0;
            step_phase = PH_TRIG;
        end
    end

    // clamp the width, scale by reciprocals of 10 and 73 (with a 5/4 step), clamp to CM_MAX
    always_comb
    begin
        dist_w    = (EXT_W'(width_reg) >= EXT_W'(DIST_SAT)) ? DIST_SAT : DIST_W'(width_reg);
        prod_ten  = PT_W'(dist_w) * PT_W'(RCP_TEN);
        q_calc    = prod_ten[RCP_SHIFT +: QT_W];
        five_q    = FQ_W'({q_reg, 2'b00}) + FQ_W'(q_reg);
        prod_cm   = PC_W'(five_q[FQ_W-1:2]) * PC_W'(RCP_73);
        cm_full   = prod_cm[RCP_SHIFT +: CMF_W];
        sample_cm = (cm_full > CMF_W'(CM_MAX)) ? CM_MAX : cm_full[CM_W-1:0];
    end

    assign div_num = sum_reg;
    assign div_den = DEN_W'(samples_reg);

    ura_divider #(
        .DIV_W (SUM_W),
        .DN_W  (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (quot),
        .done  (div_done)
    );

    assign avg_cm    = quot[CM_W-1:0];
    assign eff_batch = (batch_reg == '0) ? BATCH_W'(1) : batch_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        samples_next   = samples_reg;
        sum_next       = sum_reg;
        work_next      = work_reg;
        out_valid_next = out_valid_reg;
        if (cmd.step)
        begin
            phase_next = step_phase;
            tick_next  = step_tick;
            if (clear_batch)
            begin
                samples_next = '0;
                sum_next     = '0;
            end
            work_next                  = '0;
            work_next.trigger_out      = trig;
            work_next.drive_forward    = drive;
            work_next.sample_timed_out = timed_out;
        end
        if (cmd.add_sample)
        begin
            work_next.sample_valid = 1'b1;
            work_next.sample_cm    = sample_cm;
            sum_next               = SUM_W'(sum_reg + SUM_W'(sample_cm));
            samples_next = (samples_reg == SAMPLES_MAX) ? samples_reg
                                                        : BATCH_W'(samples_reg + 1'b1);
        end
        if (cmd.finish_avg)
        begin
            work_next.average_valid = 1'b1;
            work_next.average_cm    = avg_cm;
            samples_next            = '0;
            sum_next                = '0;
            if (avg_cm < stop_reg)
            begin
                work_next.run_done      = 1'b1;
                work_next.drive_forward = 1'b0;
                phase_next              = PH_IDLE;
            end
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg     <= BATCH_RESET;
            stop_reg      <= STOP_RESET;
            timeout_reg   <= TMO_RESET;
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            samples_reg   <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            samples_reg   <= samples_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BATCH_SIZE:    batch_reg   <= cfg_data[BATCH_W-1:0];
                    REG_STOP_DISTANCE: stop_reg    <= cfg_data[CM_W-1:0];
                    REG_TIMEOUT_TICKS: timeout_reg <= cfg_data[TMO_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (cmd.take_in)
        begin
            echo_reg  <= echo_level;
            start_reg <= start_run;
        end
        if (cmd.step)
        begin
            width_reg <= width;
        end
        if (cmd.cm_stage)
        begin
            q_reg <= q_calc;
        end
        if (cmd.load_out)
        begin
            out_reg <= work_reg;
        end
    end

    assign status.complete   = complete;
    assign status.div_done   = div_done;
    assign status.batch_full = samples_reg >= eff_batch;
    assign status.out_free   = !out_valid_reg || result.ready;

    assign result.valid            = out_valid_reg;
    assign result.trigger_out      = out_reg.trigger_out;
    assign result.drive_forward    = out_reg.drive_forward;
    assign result.sample_valid     = out_reg.sample_valid;
    assign result.sample_cm        = out_reg.sample_cm;
    assign result.sample_timed_out = out_reg.sample_timed_out;
    assign result.average_valid    = out_reg.average_valid;
    assign result.average_cm       = out_reg.average_cm;
    assign result.run_done         = out_reg.run_done;

endmodule

### src/ura_controller.sv
// ============================================================================
// ura_controller
// Sequences one tick: step, distance scaling, batch average, output load.
// ============================================================================
module ura_controller import ura_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    output logic       tick_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        tick_ready  = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                tick_ready = 1'b1;
                if (tick_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = CS_STEP;
                end
            end
            CS_STEP:
            begin
                cmd.step = 1'b1;
                if (status.complete)
                begin
                    state_next = CS_CM_A;
                end
                else
                begin
                    state_next = CS_OUT;
                end
            end
            CS_CM_A:
            begin
                cmd.cm_stage = 1'b1;
                state_next   = CS_CM_B;
            end
            CS_CM_B:
            begin
                cmd.add_sample = 1'b1;
                state_next     = CS_SUM;
            end
            CS_SUM:
            begin
                if (status.batch_full)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = CS_AVG;
                end
                else
                begin
                    state_next = CS_OUT;
                end
            end
            CS_AVG:
            begin
                if (status.div_done)
                begin
                    cmd.finish_avg = 1'b1;
                    state_next     = CS_OUT;
                end
            end
            CS_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

### src/ultrasonic_range_averager.sv
// ============================================================================
// ultrasonic_range_averager
// Ultrasonic echo ranger with batch averaging and a forward-drive stop.
// ============================================================================
// One input word is one 10 us tick; each tick gives exactly one output word.
// A tick that completes no sample only steps the ranging phase and loads the
// output. For a completed sample the echo width is latched, scaled to
// centimeters by two registered reciprocal multiplies, and added to the batch
// sum. The tick that closes a batch also runs the bit-serial divider for the
// average, which makes it the longest tick. A finished word sits in the
// output register, and the next tick is taken while it waits; that tick
// then holds in its last cycle until the register frees. Configuration is
// written via cfg_we, cfg_index and cfg_data; the user must write it only
// while no tick is in flight, as the block itself does not enforce this.
module ultrasonic_range_averager import ura_pkg::*; #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ura_tick_if.sink              tick,
    ura_result_if.source          result
);

    ctl_cmd_t   cmd;
    dp_status_t status;
    logic       tick_ready;

    ura_controller u_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick.valid),
        .tick_ready (tick_ready),
        .status     (status),
        .cmd        (cmd)
    );

    ura_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .echo_level (tick.echo_level),
        .start_run  (tick.start_run),
        .cmd        (cmd),
        .status     (status),
        .result     (result)
    );

    assign tick.ready = tick_ready;

endmodule
